/* hw/rtl/aaes_pkg.sv */
// Shared types and constants of the execute stage: item layouts, opcodes, flag positions.
// Depends on nothing; every other file of the block depends on it.
package aaes_pkg;

    localparam int unsigned XLEN        = 32;
    localparam int unsigned REG_COUNT   = 16;
    localparam int unsigned REG_IDX_W   = 4;
    localparam int unsigned BOFF_W      = 24;
    localparam int unsigned BOFF_SEXT_W = 6;
    localparam int unsigned OPCODE_W    = 8 - 4;

    // Instruction classes.
    localparam logic [1:0] KIND_DP  = 2'd0;
    localparam logic [1:0] KIND_MUL = 2'd1;
    localparam logic [1:0] KIND_BR  = 2'd2;

    // Data-processing opcodes.
    localparam logic [OPCODE_W-1:0] OP_AND = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_EOR = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_RSB = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_ADD = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_TST = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_TEQ = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_CMP = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_ORR = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_MOV = 4'd13;

    localparam logic [REG_IDX_W-1:0] PC_INDEX = 4'd15;

    // Bit positions inside the NZCV word.
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    typedef logic [XLEN-1:0]      t_word;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    typedef logic [3:0]           t_flags;

    typedef struct packed {
        logic [1:0]          kind;
        logic [OPCODE_W-1:0] alu_op;
        logic                set_flags;
        t_reg_idx            dest_reg;
        t_reg_idx            first_reg;
        t_reg_idx            mult_reg_a;
        t_reg_idx            mult_reg_b;
        logic                accumulate;
        t_word               second_operand;
        logic                shifter_carry;
        logic [BOFF_W-1:0]   br_disp;
    } t_in_item;

    typedef struct packed {
        logic     reg_written;
        t_reg_idx written_index;
        t_word    written_value;
        t_flags   flags_nzcv;
    } t_out_item;

    // Read request to the register file: three addresses issued together.
    typedef struct packed {
        logic     en;
        t_reg_idx addr_n;
        t_reg_idx addr_m;
        t_reg_idx addr_s;
    } t_rf_rd;

    // Write request to the register file.
    typedef struct packed {
        logic     en;
        t_reg_idx addr;
        t_word    data;
    } t_rf_wr;

endpackage

/* hw/rtl/aaes_in_if.sv */
// Input channel of the execute stage: valid, ready and one decoded instruction.
// Depends on aaes_pkg for the item layout.
interface aaes_in_if;
    logic               valid;
    logic               ready;
    aaes_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/aaes_out_if.sv */
// Output channel of the execute stage: valid, ready and one result beat.
// Depends on aaes_pkg for the item layout.
interface aaes_out_if;
    logic                valid;
    logic                ready;
    aaes_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/aaes_regfile.sv */
// Register file: two synchronous memory copies with registered read data,
// reset-valid bits and write-to-read forwarding. Depends on aaes_pkg.
module aaes_regfile (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  aaes_pkg::t_rf_rd i_rd,
    input  aaes_pkg::t_rf_wr i_wr,
    output aaes_pkg::t_word  o_op_n,
    output aaes_pkg::t_word  o_op_m,
    output aaes_pkg::t_word  o_op_s
);
    import aaes_pkg::*;

    // Copy 0 serves the Rn and Rm ports, copy 1 the Rs port.
    t_word r_mem0 [REG_COUNT];
    t_word r_mem1 [REG_COUNT];

    logic [REG_COUNT-1:0] r_vld;

    t_word r_dat_n, r_dat_m, r_dat_s;
    logic  r_rv_n, r_rv_m, r_rv_s;
    logic  r_hit_n, r_hit_m, r_hit_s;
    t_word r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem0[i_wr.addr] <= i_wr.data;
            r_mem1[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_dat_n    <= r_mem0[i_rd.addr_n];
            r_dat_m    <= r_mem0[i_rd.addr_m];
            r_dat_s    <= r_mem1[i_rd.addr_s];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rv_n  <= 1'b0;
            r_rv_m  <= 1'b0;
            r_rv_s  <= 1'b0;
            r_hit_n <= 1'b0;
            r_hit_m <= 1'b0;
            r_hit_s <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rv_n  <= r_vld[i_rd.addr_n];
                r_rv_m  <= r_vld[i_rd.addr_m];
                r_rv_s  <= r_vld[i_rd.addr_s];
                // A write in the same cycle as the read is not seen by the memory.
                r_hit_n <= i_wr.en && (i_wr.addr == i_rd.addr_n);
                r_hit_m <= i_wr.en && (i_wr.addr == i_rd.addr_m);
                r_hit_s <= i_wr.en && (i_wr.addr == i_rd.addr_s);
            end
        end
    end

    assign o_op_n = r_hit_n ? r_fwd_data : (r_rv_n ? r_dat_n : '0);
    assign o_op_m = r_hit_m ? r_fwd_data : (r_rv_m ? r_dat_m : '0);
    assign o_op_s = r_hit_s ? r_fwd_data : (r_rv_s ? r_dat_s : '0);

endmodule

/* hw/rtl/aaes_alu.sv */
// Execute datapath: shared adder for the arithmetic ops, logic ops, multiply-accumulate,
// branch target and flag update. Depends on aaes_pkg.
module aaes_alu (
    input  aaes_pkg::t_in_item  i_item,
    input  aaes_pkg::t_word     i_op_n,
    input  aaes_pkg::t_word     i_op_m,
    input  aaes_pkg::t_word     i_op_s,
    input  aaes_pkg::t_flags    i_flags,
    output aaes_pkg::t_out_item o_res
);
    import aaes_pkg::*;

    t_word          add_x;
    t_word          add_y;
    logic           add_cin;
    logic [XLEN:0]  add_sum;
    t_word          prod;
    t_word          mac;
    t_word          br_delta;
    t_word          dp_res;
    logic           dp_carry;
    logic           dp_known;
    logic           dp_writes;

    // One adder serves ADD, SUB, RSB and CMP; its carry out is the C flag (no borrow for SUB, RSB, CMP).
    always_comb begin
        add_x   = i_op_n;
        add_y   = i_item.second_operand;
        add_cin = 1'b0;
        case (i_item.alu_op)
            OP_SUB, OP_CMP: begin
                add_y   = ~i_item.second_operand;
                add_cin = 1'b1;
            end
            OP_RSB: begin
                add_x   = i_item.second_operand;
                add_y   = ~i_op_n;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{XLEN{1'b0}}, add_cin};

    always_comb begin
        dp_res    = '0;
        dp_carry  = i_item.shifter_carry;
        dp_known  = 1'b1;
        dp_writes = 1'b1;
        case (i_item.alu_op)
            OP_AND: dp_res = i_op_n & i_item.second_operand;
            OP_EOR: dp_res = i_op_n ^ i_item.second_operand;
            OP_ORR: dp_res = i_op_n | i_item.second_operand;
            OP_MOV: dp_res = i_item.second_operand;
            OP_SUB, OP_RSB, OP_ADD: begin
                dp_res   = add_sum[XLEN-1:0];
                dp_carry = add_sum[XLEN];
            end
            OP_TST: begin
                dp_res    = i_op_n & i_item.second_operand;
                dp_writes = 1'b0;
            end
            OP_TEQ: begin
                dp_res    = i_op_n ^ i_item.second_operand;
                dp_writes = 1'b0;
            end
            OP_CMP: begin
                dp_res    = add_sum[XLEN-1:0];
                dp_carry  = add_sum[XLEN];
                dp_writes = 1'b0;
            end
            default: dp_known = 1'b0;
        endcase
    end

    // Low word of the product only; the sum wraps.
    assign prod     = i_op_m * i_op_s;
    assign mac      = prod + (i_item.accumulate ? i_op_n : '0);
    assign br_delta = {{BOFF_SEXT_W{i_item.br_disp[BOFF_W-1]}},
                       i_item.br_disp, 2'b00};

    always_comb begin
        o_res = '{reg_written: 1'b0, written_index: '0, written_value: '0,
                  flags_nzcv: i_flags};
        case (i_item.kind)
            KIND_DP: begin
                if (dp_known) begin
                    if (dp_writes) begin
                        o_res.reg_written   = 1'b1;
                        o_res.written_index = i_item.dest_reg;
                        o_res.written_value = dp_res;
                    end
                    if (i_item.set_flags) begin
                        o_res.flags_nzcv[FLAG_N] = dp_res[XLEN-1];
                        o_res.flags_nzcv[FLAG_Z] = (dp_res == '0);
                        o_res.flags_nzcv[FLAG_C] = dp_carry;
                    end
                end
            end
            KIND_MUL: begin
                o_res.reg_written   = 1'b1;
                o_res.written_index = i_item.dest_reg;
                o_res.written_value = mac;
                if (i_item.set_flags) begin
                    o_res.flags_nzcv[FLAG_N] = mac[XLEN-1];
                    o_res.flags_nzcv[FLAG_Z] = (mac == '0);
                end
            end
            KIND_BR: begin
                o_res.reg_written   = 1'b1;
                o_res.written_index = PC_INDEX;
                o_res.written_value = i_op_n + br_delta;
            end
            default: begin
                o_res.reg_written = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/arm_alu_execute_stage.sv */
// Top level of the execute stage: input beat capture, register file read, execute and
// result register. Depends on aaes_pkg, aaes_in_if, aaes_out_if, aaes_regfile, aaes_alu.

// The stage takes decoded instruction beats (data processing, multiply or branch) and
// returns exactly one result beat for each, in order. When a beat is accepted its source
// registers (Rn, or the PC for a branch, plus Rm and Rs) are read from a 16 x 32 register
// file kept in two synchronous memory copies; the operation then executes from the
// registered beat, and once the output register is free or being emptied the destination
// is written back and the result, with the NZCV flags after the instruction, is loaded into
// the output register. A full stream sustains one beat per cycle while the sink takes each result.
// The cycle time is set by the execute step: a 32 x 32 multiply followed by the accumulate
// add, or the shared 33-bit adder, between the operand registers and the write port.
// A register written by the instruction just ahead is forwarded around the memory, so
// dependent instructions issue back to back with no bubble. The flags live in a register
// and are always current for the next instruction. After reset every register reads as zero
// through per-entry valid bits, so there is no clearing pass and a beat can be taken as soon
// as reset is released. Input ready drops only while an executed result is stalled behind
// a full output register that the sink does not take.
module arm_alu_execute_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aaes_in_if.sink    i_in,
    aaes_out_if.source o_out
);
    import aaes_pkg::*;

    // Execute stage holding register.
    logic     r_s1_vld;
    t_in_item r_s1;

    // Result register.
    logic      r_out_vld;
    t_out_item r_out;

    t_flags r_flags;

    logic      in_acc;
    logic      s1_adv;
    t_rf_rd    rf_rd;
    t_rf_wr    rf_wr;
    t_word     op_n;
    t_word     op_m;
    t_word     op_s;
    t_out_item ex_res;

    assign s1_adv     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // A branch reads the PC on the Rn port.
    assign rf_rd.en     = in_acc;
    assign rf_rd.addr_n = (i_in.data.kind == KIND_BR) ? PC_INDEX : i_in.data.first_reg;
    assign rf_rd.addr_m = i_in.data.mult_reg_a;
    assign rf_rd.addr_s = i_in.data.mult_reg_b;

    assign rf_wr.en   = s1_adv && ex_res.reg_written;
    assign rf_wr.addr = ex_res.written_index;
    assign rf_wr.data = ex_res.written_value;

    aaes_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_op_n  (op_n),
        .o_op_m  (op_m),
        .o_op_s  (op_s)
    );

    aaes_alu u_alu (
        .i_item  (r_s1),
        .i_op_n  (op_n),
        .i_op_m  (op_m),
        .i_op_s  (op_s),
        .i_flags (r_flags),
        .o_res   (ex_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_flags   <= ex_res.flags_nzcv;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.data;
        end
        if (s1_adv) begin
            r_out <= ex_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // Input is refused only while an executed instruction waits.
    a_ready_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_vld)
        else $error("input refused while the execute stage is empty");

    // No instruction class ever sets V, so it stays clear after reset.
    a_v_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !r_flags[FLAG_V])
        else $error("V flag became set");

    // Flags change only when an instruction retires.
    a_flags_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(s1_adv) |-> $stable(r_flags))
        else $error("flags changed without a retiring instruction");

    // A branch always writes the PC.
    a_branch_writes_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (r_s1.kind == KIND_BR) |-> rf_wr.en && (rf_wr.addr == PC_INDEX))
        else $error("branch did not write the PC");

    // A new result beat comes only from a retiring instruction.
    a_out_from_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_vld) |-> $past(s1_adv))
        else $error("result beat without a retiring instruction");

endmodule
